// ===== sv/scebp_pkg.sv =====
// ----------------------------------------------------------------------------
// scebp_pkg
// Shared types and constants of the softmax cross entropy backprop block.
// ----------------------------------------------------------------------------
package scebp_pkg;

  // layer geometry
  localparam int ROW_COUNT   = 64;
  localparam int KERN_COUNT  = 16;

  // field widths
  localparam int ROW_W       = 6;
  localparam int KERN_W      = 4;
  localparam int ADDR_W      = ROW_W + KERN_W;
  localparam int STORE_DEPTH = 1 << ADDR_W;
  localparam int KERN_SLOTS  = 1 << KERN_W;
  localparam int WEIGHT_W    = 16;
  localparam int PRED_W      = 16;
  localparam int ERR_W       = 18;
  localparam int PROD_W      = WEIGHT_W + ERR_W;
  localparam int ACC_W       = PROD_W + KERN_W;
  localparam int RES_W       = 32;
  localparam int FRAC_SHIFT  = 12;

  // queue sizes
  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = 2;
  localparam int CMDQ_CNT_W  = 3;
  localparam int RESQ_DEPTH  = 2;
  localparam int RESQ_PTR_W  = 1;
  localparam int RESQ_CNT_W  = 2;

  // fixed-point constants
  localparam logic [ROW_W-1:0]         LAST_ROW   = ROW_W'(ROW_COUNT - 1);
  localparam logic [KERN_W-1:0]        LAST_KERN  = KERN_W'(KERN_COUNT - 1);
  localparam logic signed [ERR_W-1:0]  ONE_Q16    = 18'sd65536;
  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(2048);
  localparam logic signed [RES_W-1:0]  RES_MAX    = 32'sh7fffffff;
  localparam logic signed [RES_W-1:0]  RES_MIN    = 32'sh80000000;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_PRED = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_ERR,
    CMD_RUN
  } cmd_op_e;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    cmd_op_e                    op;
    logic [ADDR_W-1:0]          addr;
    logic [KERN_W-1:0]          kern;
    logic signed [WEIGHT_W-1:0] weight;
    logic signed [ERR_W-1:0]    err;
  } cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]        row;
    logic signed [RES_W-1:0] value;
    logic                    last;
  } res_t;

endpackage

// ===== sv/scebp_ram.sv =====
// ----------------------------------------------------------------------------
// scebp_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module scebp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scebp_front.sv =====
// ----------------------------------------------------------------------------
// scebp_front
// Accepts items, drops out-of-range ones, turns the rest into commands
// (weight load, error update, error update plus run) and queues them.
// ----------------------------------------------------------------------------
module scebp_front import scebp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type_i,
  input  logic [ROW_W-1:0]           row_index_i,
  input  logic [KERN_W-1:0]          kernel_index_i,
  input  logic signed [WEIGHT_W-1:0] weight_value_i,
  input  logic [PRED_W-1:0]          prediction_i,
  input  logic [KERN_W-1:0]          class_label_i,
  output logic                       cmd_valid_o,
  output cmd_t                       cmd_o,
  input  logic                       cmd_pop_i
);

  cmd_t                  cmd_new;
  logic                  keep;
  logic                  in_accept;
  logic                  wr_en;
  logic                  rd_en;
  cmd_t                  fifo_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CMDQ_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  row_ok;
  logic                  kern_ok;

  assign row_ok  = {1'b0, row_index_i} < (ROW_W + 1)'(ROW_COUNT);
  assign kern_ok = {1'b0, kernel_index_i} < (KERN_W + 1)'(KERN_COUNT);

  // classify the incoming item
  always_comb begin
    cmd_new        = '0;
    keep           = 1'b0;
    cmd_new.addr   = {row_index_i, kernel_index_i};
    cmd_new.kern   = kernel_index_i;
    cmd_new.weight = weight_value_i;
    cmd_new.err    = $signed({2'b00, prediction_i})
                     - ((class_label_i == kernel_index_i) ? ONE_Q16 : '0);
    case (req_type_e'(req_type_i))
      REQ_LOAD: begin
        cmd_new.op = CMD_LOAD;
        keep       = row_ok && kern_ok;
      end
      REQ_PRED: begin
        cmd_new.op = (kernel_index_i == LAST_KERN) ? CMD_RUN : CMD_ERR;
        keep       = kern_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // command queue control
  assign full        = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign in_accept   = push && !full;
  assign wr_en       = in_accept && keep;
  assign cmd_valid_o = (cnt_q != '0);
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!wr_en && rd_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // command queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign cmd_o = fifo_q[rd_ptr_q];

endmodule

// ===== sv/scebp_back.sv =====
// ----------------------------------------------------------------------------
// scebp_back
// Executes commands: weight writes, error buffer writes, and the row by row
// matrix-vector product through one multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module scebp_back import scebp_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cmd_valid_i,
  input  cmd_t                    cmd_i,
  output logic                    cmd_pop_o,
  output logic                    empty,
  input  logic                    pop,
  output logic [ROW_W-1:0]        input_row_o,
  output logic signed [RES_W-1:0] error_value_o,
  output logic                    last_row_o
);

  seq_state_e              seq_q, seq_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [KERN_W-1:0]       kern_q, kern_d;
  logic                    issue;
  logic                    ram_we;
  logic                    err_we;
  logic                    stall;
  logic                    adv;
  logic [WEIGHT_W-1:0]     ram_rdata;
  logic signed [WEIGHT_W-1:0] w_rd;
  logic signed [ERR_W-1:0] err_q [KERN_SLOTS];

  logic                    s1_v_q;
  logic                    s1_first_q, s1_last_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic signed [ERR_W-1:0] s1_err_q;

  logic                    s2_v_q;
  logic                    s2_first_q, s2_last_q;
  logic [ROW_W-1:0]        s2_row_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;

  logic signed [ACC_W-1:0] acc_q;
  logic                    res_pend_q;
  logic [ROW_W-1:0]        res_row_q;
  logic signed [ACC_W-1:0] shifted;
  logic                    fits;
  res_t                    res_new;
  logic                    res_push;

  res_t                    resq_q [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0]   rq_wr_q, rq_rd_q;
  logic [RESQ_CNT_W-1:0]   rq_cnt_q, rq_cnt_d;
  logic                    resq_full;
  logic                    res_pop;

  // pipeline freezes only when a finished row cannot be queued
  assign resq_full = (rq_cnt_q == RESQ_CNT_W'(RESQ_DEPTH));
  assign stall     = res_pend_q && resq_full;
  assign adv       = !stall;

  // sequencer: command dispatch and row/kernel walk
  always_comb begin
    seq_d     = seq_q;
    row_d     = row_q;
    kern_d    = kern_q;
    cmd_pop_o = 1'b0;
    ram_we    = 1'b0;
    err_we    = 1'b0;
    issue     = 1'b0;
    case (seq_q)
      SEQ_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            CMD_LOAD: ram_we = 1'b1;
            CMD_ERR:  err_we = 1'b1;
            CMD_RUN: begin
              err_we = 1'b1;
              seq_d  = SEQ_RUN;
              row_d  = '0;
              kern_d = '0;
            end
            default: ;
          endcase
        end
      end
      SEQ_RUN: begin
        if (adv) begin
          issue = 1'b1;
          if (kern_q == LAST_KERN) begin
            kern_d = '0;
            if (row_q == LAST_ROW) begin
              seq_d = SEQ_IDLE;
            end else begin
              row_d = row_q + 1'b1;
            end
          end else begin
            kern_d = kern_q + 1'b1;
          end
        end
      end
      default: seq_d = SEQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= SEQ_IDLE;
      row_q  <= '0;
      kern_q <= '0;
    end else begin
      seq_q  <= seq_d;
      row_q  <= row_d;
      kern_q <= kern_d;
    end
  end

  // weight store
  scebp_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (STORE_DEPTH)
  ) u_weights (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.addr),
    .wdata_i (cmd_i.weight),
    .re_i    (issue),
    .raddr_i ({row_q, kern_q}),
    .rdata_o (ram_rdata)
  );

  // error buffer, one entry per kernel
  always_ff @(posedge clk_i) begin
    if (err_we) begin
      err_q[cmd_i.kern] <= cmd_i.err;
    end
  end

  // stage 1: weight read in flight, error picked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && issue) begin
      s1_first_q <= (kern_q == '0);
      s1_last_q  <= (kern_q == LAST_KERN);
      s1_row_q   <= row_q;
      s1_err_q   <= err_q[kern_q];
    end
  end

  // stage 2: product
  assign w_rd   = ram_rdata;
  assign prod_d = w_rd * s1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (adv) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_row_q   <= s1_row_q;
      prod_q     <= prod_d;
    end
  end

  // accumulate, rounding bias seeded on the first kernel
  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      acc_q <= (s2_first_q ? ROUND_HALF : acc_q)
               + {{(ACC_W - PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (adv && s2_v_q && s2_last_q) begin
      res_row_q <= s2_row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_pend_q <= 1'b0;
    end else if (adv && s2_v_q && s2_last_q) begin
      res_pend_q <= 1'b1;
    end else if (res_push) begin
      res_pend_q <= 1'b0;
    end
  end

  // scale to Q15.16 and saturate
  assign shifted = acc_q >>> FRAC_SHIFT;
  assign fits    = (shifted[ACC_W-1:RES_W-1] == '0) || (shifted[ACC_W-1:RES_W-1] == '1);

  always_comb begin
    res_new.row   = res_row_q;
    res_new.last  = (res_row_q == LAST_ROW);
    res_new.value = fits ? shifted[RES_W-1:0] : (shifted[ACC_W-1] ? RES_MIN : RES_MAX);
  end

  assign res_push = res_pend_q && !resq_full;

  // result queue
  assign empty   = (rq_cnt_q == '0);
  assign res_pop = pop && !empty;

  always_comb begin
    rq_cnt_d = rq_cnt_q;
    if (res_push && !res_pop) begin
      rq_cnt_d = rq_cnt_q + 1'b1;
    end else if (!res_push && res_pop) begin
      rq_cnt_d = rq_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= '0;
      rq_rd_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      rq_cnt_q <= rq_cnt_d;
      if (res_push) begin
        rq_wr_q <= rq_wr_q + 1'b1;
      end
      if (res_pop) begin
        rq_rd_q <= rq_rd_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      resq_q[rq_wr_q] <= res_new;
    end
  end

  assign input_row_o   = resq_q[rq_rd_q].row;
  assign error_value_o = resq_q[rq_rd_q].value;
  assign last_row_o    = resq_q[rq_rd_q].last;

`ifndef SYNTHESIS
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> (seq_q == SEQ_IDLE))
    else $error("command taken while product sequence runs");

  a_resq_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_cnt_q <= RESQ_CNT_W'(RESQ_DEPTH))
    else $error("result queue overfilled");

  a_stall_holds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall |=> $stable(acc_q))
    else $error("accumulator moved during stall");

  a_row_end_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && s2_v_q && s2_last_q) |=> res_pend_q)
    else $error("finished row not marked pending");
`endif

endmodule

// ===== sv/softmax_cross_entropy_backprop_top.sv =====
// ----------------------------------------------------------------------------
// softmax_cross_entropy_backprop_top
// Softmax cross entropy backward pass: weight loads, error buffering and
// propagation of the error to the layer inputs.
// ----------------------------------------------------------------------------
// Usage:
//  Input side is a queue: an item is taken when push is high and full is low.
//  Weight loads and predictions for kernels other than the last go through a
//  4-entry command queue; full rises only when it fills. The prediction for
//  the last kernel starts the product: 64 rows times 16 kernels, one weight
//  read and one multiply-accumulate per cycle while the result queue has room,
//  a rate set by the single weight store read port and the single multiplier.
//  Further items wait in the command queue while the product runs.
//  Output side is a queue: results are valid while empty is low and taken
//  when pop is high; last_row_o marks the final row of a sample.
//  When pop stays low the 2-entry result queue fills and the product pipeline
//  freezes in place, nothing is lost. Reset empties both queues and idles the
//  sequencer; weights and errors are undefined until written.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_backprop_top import scebp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       req_type_i,
  input  logic [ROW_W-1:0]           row_index_i,
  input  logic [KERN_W-1:0]          kernel_index_i,
  input  logic signed [WEIGHT_W-1:0] weight_value_i,
  input  logic [PRED_W-1:0]          prediction_i,
  input  logic [KERN_W-1:0]          class_label_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [ROW_W-1:0]           input_row_o,
  output logic signed [RES_W-1:0]    error_value_o,
  output logic                       last_row_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  // item intake and classification
  scebp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .kernel_index_i (kernel_index_i),
    .weight_value_i (weight_value_i),
    .prediction_i   (prediction_i),
    .class_label_i  (class_label_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  // execution and result queue
  scebp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd),
    .cmd_pop_o     (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .input_row_o   (input_row_o),
    .error_value_o (error_value_o),
    .last_row_o    (last_row_o)
  );

endmodule

// ===== bench/scebp_row_error_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scebp_row_error_checker
// Watches both queue sides of the backprop block. Each accepted item updates a
// private copy of the weight store and error buffer. A last-kernel prediction
// queues the 64 expected row errors, and each popped result is compared with
// the oldest one.
// ----------------------------------------------------------------------------
module scebp_row_error_checker import scebp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  input  logic                       full,
  input  logic                       req_type_i,
  input  logic [ROW_W-1:0]           row_index_i,
  input  logic [KERN_W-1:0]          kernel_index_i,
  input  logic signed [WEIGHT_W-1:0] weight_value_i,
  input  logic [PRED_W-1:0]          prediction_i,
  input  logic [KERN_W-1:0]          class_label_i,
  input  logic                       empty,
  input  logic                       pop,
  input  logic [ROW_W-1:0]           input_row_o,
  input  logic signed [RES_W-1:0]    error_value_o,
  input  logic                       last_row_o,
  output int                         mismatch_count_o,
  output int                         rows_waiting_o
);

  // private copy of the block state
  logic signed [WEIGHT_W-1:0] weight_mem [STORE_DEPTH];
  logic signed [ERR_W-1:0]    kernel_err [KERN_SLOTS];
  res_t                       row_expect_q [$];
  int                         fails = 0;
  int                         waiting = 0;

  assign mismatch_count_o = fails;
  assign rows_waiting_o   = waiting;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    fails++;
  endtask

  // round q.28 to q.16 by adding half and flooring, then clamp to 32 bits
  function automatic logic signed [RES_W-1:0] round_to_q16(input longint acc);
    longint q;
    q = (acc + 64'sd2048) >>> FRAC_SHIFT;
    if (q > 64'sh7fffffff) q = 64'sh7fffffff;
    if (q < -64'sh80000000) q = -64'sh80000000;
    return q[RES_W-1:0];
  endfunction

  // one expected error per input row: sum over kernels of weight times error
  task automatic propagate_rows();
    longint acc;
    res_t   row_res;
    for (int r = 0; r < ROW_COUNT; r++) begin
      acc = 0;
      for (int k = 0; k < KERN_COUNT; k++) begin
        acc += longint'(weight_mem[ADDR_W'(r * KERN_SLOTS + k)]) *
               longint'(kernel_err[k]);
      end
      row_res.row   = ROW_W'(r);
      row_res.value = round_to_q16(acc);
      row_res.last  = (r == ROW_COUNT - 1);
      row_expect_q.push_back(row_res);
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      // popped result against the oldest expectation
      if (pop && !empty) begin
        if (row_expect_q.size() == 0) begin
          report_mismatch("unexpected result, row", input_row_o, -1);
        end else begin
          want = row_expect_q.pop_front();
          if (input_row_o !== want.row)
            report_mismatch("input_row", input_row_o, want.row);
          if (error_value_o !== want.value)
            report_mismatch("error_value", error_value_o, want.value);
          if (last_row_o !== want.last)
            report_mismatch("last_row", last_row_o, want.last);
        end
      end
      // accepted item updates the state copy
      if (push && !full) begin
        if (req_type_i == REQ_LOAD) begin
          if (row_index_i < ROW_COUNT && kernel_index_i < KERN_COUNT)
            weight_mem[{row_index_i, kernel_index_i}] = weight_value_i;
        end else if (kernel_index_i < KERN_COUNT) begin
          kernel_err[kernel_index_i] = $signed({2'b00, prediction_i}) -
            ((class_label_i == kernel_index_i) ? ONE_Q16 : 18'sd0);
          if (kernel_index_i == LAST_KERN) propagate_rows();
        end
      end
      waiting <= row_expect_q.size();
    end
  end

endmodule

// ===== bench/softmax_cross_entropy_backprop_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_cross_entropy_backprop_top_tb
// Fills the whole weight store, runs a few directed samples with extreme
// weights and predictions, then random samples, weight reloads and stray
// predictions with random gaps on both sides. The checker beside the block
// predicts and compares every row result.
// ----------------------------------------------------------------------------
module softmax_cross_entropy_backprop_top_tb;
  import scebp_pkg::*;

  localparam int CYCLE_LIMIT  = 12_000_000;
  localparam int RANDOM_ITEMS = 380;
  localparam int HOLD_CYCLES  = 2500;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       push;
  logic                       full;
  logic                       req_type_i;
  logic [ROW_W-1:0]           row_index_i;
  logic [KERN_W-1:0]          kernel_index_i;
  logic signed [WEIGHT_W-1:0] weight_value_i;
  logic [PRED_W-1:0]          prediction_i;
  logic [KERN_W-1:0]          class_label_i;
  logic                       empty;
  logic                       pop;
  logic [ROW_W-1:0]           input_row_o;
  logic signed [RES_W-1:0]    error_value_o;
  logic                       last_row_o;
  int                         mismatches;
  int                         rows_waiting;
  int                         cycle_count = 0;
  bit                         send_calm;
  bit                         pop_calm;

  softmax_cross_entropy_backprop_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .req_type_i     (req_type_i),
    .row_index_i    (row_index_i),
    .kernel_index_i (kernel_index_i),
    .weight_value_i (weight_value_i),
    .prediction_i   (prediction_i),
    .class_label_i  (class_label_i),
    .empty          (empty),
    .pop            (pop),
    .input_row_o    (input_row_o),
    .error_value_o  (error_value_o),
    .last_row_o     (last_row_o)
  );

  scebp_row_error_checker checker_u (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .req_type_i       (req_type_i),
    .row_index_i      (row_index_i),
    .kernel_index_i   (kernel_index_i),
    .weight_value_i   (weight_value_i),
    .prediction_i     (prediction_i),
    .class_label_i    (class_label_i),
    .empty            (empty),
    .pop              (pop),
    .input_row_o      (input_row_o),
    .error_value_o    (error_value_o),
    .last_row_o       (last_row_o),
    .mismatch_count_o (mismatches),
    .rows_waiting_o   (rows_waiting)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("softmax_cross_entropy_backprop_top test failed");
      $finish;
    end
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  // predictions lean on the extremes now and then
  function automatic logic [PRED_W-1:0] pick_pred();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PRED_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // offer one item after a random gap and hold it until taken
  task automatic offer_request(input req_type_e rt, input logic [ROW_W-1:0] row,
                               input logic [KERN_W-1:0] kern,
                               input logic signed [WEIGHT_W-1:0] w,
                               input logic [PRED_W-1:0] pred,
                               input logic [KERN_W-1:0] label);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    req_type_i     <= rt;
    row_index_i    <= row;
    kernel_index_i <= kern;
    weight_value_i <= w;
    prediction_i   <= pred;
    class_label_i  <= label;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // unused fields carry random values
  task automatic push_load(input logic [ROW_W-1:0] row, input logic [KERN_W-1:0] kern,
                           input logic signed [WEIGHT_W-1:0] w);
    offer_request(REQ_LOAD, row, kern, w, PRED_W'($urandom), KERN_W'($urandom));
  endtask

  task automatic push_pred(input logic [KERN_W-1:0] kern, input logic [PRED_W-1:0] pred,
                           input logic [KERN_W-1:0] label);
    offer_request(REQ_PRED, ROW_W'($urandom), kern, WEIGHT_W'($urandom), pred, label);
  endtask

  // stop offering and wait for every expected row
  task automatic wait_drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (rows_waiting != 0) @(posedge clk_i);
  endtask

  // receiver: random pop gaps, one long hold-off
  initial begin
    int gap;
    int rows_popped;
    bit held;
    rows_popped = 0;
    held = 1'b0;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) pop_calm = !pop_calm;
      gap = draw_gap(pop_calm);
      if (!held && rows_popped >= 150) begin
        gap = HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      rows_popped++;
    end
  end

  // sender and verdict
  initial begin
    int sent;
    int n;
    int j;
    int tmp;
    int order [KERN_COUNT-1];
    logic [KERN_W-1:0] label;
    bit paused;
    logic signed [WEIGHT_W-1:0] w;

    sent = 0;
    paused = 1'b0;
    rst_ni         <= 1'b0;
    push           <= 1'b0;
    req_type_i     <= REQ_LOAD;
    row_index_i    <= '0;
    kernel_index_i <= '0;
    weight_value_i <= '0;
    prediction_i   <= '0;
    class_label_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // fill every weight: row 0 at the minimum, row 1 at the maximum
    for (int r = 0; r < ROW_COUNT; r++) begin
      for (int k = 0; k < KERN_COUNT; k++) begin
        if (r == 0)      w = 16'sh8000;
        else if (r == 1) w = 16'sh7fff;
        else if (r == 2) w = '0;
        else             w = WEIGHT_W'($urandom);
        push_load(ROW_W'(r), KERN_W'(k), w);
      end
    end

    // directed: zero predictions with a hit on the label kernel
    for (int k = 0; k < KERN_COUNT; k++) push_pred(KERN_W'(k), '0, KERN_W'(7));
    // extreme reloads, then a full-scale hit and a rerun on stored errors
    push_load(ROW_W'(3), KERN_W'(0), 16'sh8000);
    push_load(ROW_W'(3), LAST_KERN, 16'sh7fff);
    push_load(LAST_ROW, LAST_KERN, -16'sd1);
    push_pred(KERN_W'(0), '1, KERN_W'(0));
    push_pred(LAST_KERN, '1, KERN_W'(3));

    // random part
    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        wait_drain();
        paused = 1'b1;
      end
      tmp = $urandom_range(0, 99);
      if (tmp < 50) begin
        // whole sample, kernels in shuffled order, last kernel closes it
        label = KERN_W'($urandom);
        for (int k = 0; k < KERN_COUNT - 1; k++) order[k] = k;
        for (int k = KERN_COUNT - 2; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = order[k];
          order[k] = order[j];
          order[j] = tmp;
        end
        for (int k = 0; k < KERN_COUNT - 1; k++)
          push_pred(KERN_W'(order[k]), pick_pred(), label);
        push_pred(LAST_KERN, pick_pred(), label);
        sent += KERN_COUNT;
      end else if (tmp < 70) begin
        // burst of weight reloads
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          push_load(ROW_W'($urandom), KERN_W'($urandom), pick_weight());
        sent += n;
      end else if (tmp < 85) begin
        // stray predictions on any kernel
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          push_pred(KERN_W'($urandom), pick_pred(), KERN_W'($urandom));
        sent += n;
      end else begin
        // broken sample that never reaches the last kernel
        n = $urandom_range(1, KERN_COUNT - 2);
        label = KERN_W'($urandom);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 5) == 0) label = KERN_W'($urandom);
          push_pred(KERN_W'($urandom_range(0, KERN_COUNT - 2)), pick_pred(), label);
        end
        sent += n;
      end
    end

    wait_drain();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("softmax_cross_entropy_backprop_top test passed");
    end else begin
      $display("softmax_cross_entropy_backprop_top test failed");
    end
    $finish;
  end

endmodule

// ===== softmax_cross_entropy_backprop_top.f =====
sv/scebp_pkg.sv
sv/scebp_ram.sv
sv/scebp_front.sv
sv/scebp_back.sv
sv/softmax_cross_entropy_backprop_top.sv
bench/scebp_row_error_checker.sv
bench/softmax_cross_entropy_backprop_top_tb.sv
